@@ src/lslr_pkg.sv @@
// Shared types and constants for the largest same-letter region block.
// Used by lslr_ctrl, lslr_dp, the top level and the checker; no dependencies.
package lslr_pkg;

   localparam int CFG_W        = 7;
   localparam int LETTER_W     = 8;
   localparam int SIZE_W       = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int DEF_MAX_ROWS = 64;
   localparam int DEF_MAX_COLS = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'd1;

   // Neighbor directions, visited in this order
   localparam logic [1:0] NB_UP    = 2'd0;
   localparam logic [1:0] NB_DOWN  = 2'd1;
   localparam logic [1:0] NB_LEFT  = 2'd2;
   localparam logic [1:0] NB_RIGHT = 2'd3;

   typedef enum logic [9:0] {
      S_LOAD     = 10'b00_0000_0001,
      S_CLEAR    = 10'b00_0000_0010,
      S_SEED     = 10'b00_0000_0100,
      S_SEED_CHK = 10'b00_0000_1000,
      S_POP      = 10'b00_0001_0000,
      S_CUR      = 10'b00_0010_0000,
      S_LET      = 10'b00_0100_0000,
      S_NB       = 10'b00_1000_0000,
      S_NB_CHK   = 10'b01_0000_0000,
      S_DONE     = 10'b10_0000_0000
   } state_type;

   typedef struct packed {
      logic load;
      logic clear_init;
      logic clear;
      logic seed_init;
      logic seed_read;
      logic seed_next;
      logic seed_take;
      logic region_end;
      logic pop;
      logic cur;
      logic letter_latch;
      logic nb_read;
      logic nb_check;
      logic nb_next;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last_clear;
      logic seed_end;
      logic vis_hit;
      logic queue_empty;
      logic nb_valid;
      logic nb_last;
      logic rsp_busy;
   } status_type;

endpackage

@@ src/lslr_ctrl.sv @@
// Sequencer for load, visited clear, seed scan and breadth-first walk.
// Depends on lslr_pkg; drives commands into lslr_dp and reads its status.
module lslr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_last_cell,
   input  lslr_pkg::status_type status,
   output lslr_pkg::cmd_type    cmd
);

   lslr_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == lslr_pkg::S_LOAD);
      case (state_ff)
         lslr_pkg::S_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last_cell) begin
                  cmd.clear_init = 1'b1;
                  state_in       = lslr_pkg::S_CLEAR;
               end
            end
         end
         lslr_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.last_clear) begin
               cmd.seed_init = 1'b1;
               state_in      = lslr_pkg::S_SEED;
            end
         end
         lslr_pkg::S_SEED: begin
            if (status.seed_end) begin
               state_in = lslr_pkg::S_DONE;
            end else begin
               cmd.seed_read = 1'b1;
               state_in      = lslr_pkg::S_SEED_CHK;
            end
         end
         lslr_pkg::S_SEED_CHK: begin
            if (status.vis_hit) begin
               cmd.seed_next = 1'b1;
               state_in      = lslr_pkg::S_SEED;
            end else begin
               cmd.seed_take = 1'b1;
               state_in      = lslr_pkg::S_POP;
            end
         end
         lslr_pkg::S_POP: begin
            if (status.queue_empty) begin
               cmd.region_end = 1'b1;
               cmd.seed_next  = 1'b1;
               state_in       = lslr_pkg::S_SEED;
            end else begin
               cmd.pop  = 1'b1;
               state_in = lslr_pkg::S_CUR;
            end
         end
         lslr_pkg::S_CUR: begin
            cmd.cur  = 1'b1;
            state_in = lslr_pkg::S_LET;
         end
         lslr_pkg::S_LET: begin
            cmd.letter_latch = 1'b1;
            state_in         = lslr_pkg::S_NB;
         end
         lslr_pkg::S_NB: begin
            if (status.nb_valid) begin
               cmd.nb_read = 1'b1;
               state_in    = lslr_pkg::S_NB_CHK;
            end else begin
               // skip a neighbor that falls off the grid edge
               cmd.nb_next = 1'b1;
               state_in    = status.nb_last ? lslr_pkg::S_POP : lslr_pkg::S_NB;
            end
         end
         lslr_pkg::S_NB_CHK: begin
            cmd.nb_check = 1'b1;
            cmd.nb_next  = 1'b1;
            state_in     = status.nb_last ? lslr_pkg::S_POP : lslr_pkg::S_NB;
         end
         lslr_pkg::S_DONE: begin
            // hold until the output register is free
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = lslr_pkg::S_LOAD;
            end
         end
         default: begin
            state_in = lslr_pkg::S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lslr_pkg::S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/lslr_dp.sv @@
// Datapath: grid, visited and queue memories, walk counters, config and result registers.
// Depends on lslr_pkg; steered by commands from lslr_ctrl.
module lslr_dp #(
   parameter int MAX_ROWS = lslr_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = lslr_pkg::DEF_MAX_COLS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [lslr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lslr_pkg::CFG_W-1:0]         csr_wdata,
   input  logic [lslr_pkg::LETTER_W-1:0]      req_letter,
   input  lslr_pkg::cmd_type                  cmd,
   output lslr_pkg::status_type               status,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [lslr_pkg::SIZE_W-1:0]        rsp_largest_size
);

   localparam int CELLS  = MAX_ROWS * MAX_COLS;
   localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CLW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int MAXC_W = (RW > CLW) ? ((RW > lslr_pkg::CFG_W) ? RW : lslr_pkg::CFG_W)
                                      : ((CLW > lslr_pkg::CFG_W) ? CLW : lslr_pkg::CFG_W);
   localparam int CMP_W  = MAXC_W + 1;
   localparam int QW     = IDX_W + RW + CLW;
   localparam int PROD_W = 2 * lslr_pkg::CFG_W;

   // config and dimensions
   logic [lslr_pkg::CFG_W-1:0] grid_rows_ff, grid_rows_in;
   logic [lslr_pkg::CFG_W-1:0] grid_cols_ff, grid_cols_in;
   logic [lslr_pkg::CFG_W-1:0] eff_rows, eff_cols;
   logic [PROD_W-1:0]          prod;
   logic [CNT_W-1:0]           total;

   // counters
   logic [CNT_W-1:0] load_idx_ff, load_idx_in;
   logic [IDX_W-1:0] clr_ptr_ff, clr_ptr_in;
   logic [CNT_W-1:0] seed_ff, seed_in;
   logic [RW-1:0]    seed_row_ff, seed_row_in;
   logic [CLW-1:0]   seed_col_ff, seed_col_in;
   logic [CNT_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] region_ff, region_in;
   logic [CNT_W-1:0] best_ff, best_in;
   logic [1:0]       nb_sel_ff, nb_sel_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [IDX_W-1:0]              cur_lin_ff, cur_lin_in;
   logic [RW-1:0]                 cur_row_ff, cur_row_in;
   logic [CLW-1:0]                cur_col_ff, cur_col_in;
   logic [lslr_pkg::LETTER_W-1:0] cur_letter_ff, cur_letter_in;
   logic [lslr_pkg::SIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   // memories
   logic [lslr_pkg::LETTER_W-1:0] cell_mem_ff [CELLS];
   logic                          vis_mem_ff  [CELLS];
   logic [QW-1:0]                 queue_mem_ff[CELLS];
   logic [lslr_pkg::LETTER_W-1:0] cell_rd_ff;
   logic                          vis_rd_ff;
   logic [QW-1:0]                 queue_rd_ff;

   logic                          cell_we;
   logic [IDX_W-1:0]              cell_waddr, cell_raddr;
   logic                          vis_we, vis_wdata;
   logic [IDX_W-1:0]              vis_waddr, vis_raddr;
   logic                          queue_we;
   logic [IDX_W-1:0]              queue_waddr;
   logic [QW-1:0]                 queue_wdata;

   // queue read fields
   logic [IDX_W-1:0] q_lin;
   logic [RW-1:0]    q_row;
   logic [CLW-1:0]   q_col;

   // neighbor under test
   logic             nb_valid;
   logic [IDX_W-1:0] nb_lin, cols_idx;
   logic [RW-1:0]    nb_row;
   logic [CLW-1:0]   nb_col;
   logic             nb_take;
   logic             col_wrap;

   assign q_lin = queue_rd_ff[QW-1 -: IDX_W];
   assign q_row = queue_rd_ff[RW+CLW-1 -: RW];
   assign q_col = queue_rd_ff[CLW-1:0];

   // clamp dimensions to 1..MAX
   always_comb begin
      if (grid_rows_ff == '0) begin
         eff_rows = lslr_pkg::CFG_W'(1);
      end else if (CMP_W'(grid_rows_ff) > CMP_W'(MAX_ROWS)) begin
         eff_rows = lslr_pkg::CFG_W'(MAX_ROWS);
      end else begin
         eff_rows = grid_rows_ff;
      end
      if (grid_cols_ff == '0) begin
         eff_cols = lslr_pkg::CFG_W'(1);
      end else if (CMP_W'(grid_cols_ff) > CMP_W'(MAX_COLS)) begin
         eff_cols = lslr_pkg::CFG_W'(MAX_COLS);
      end else begin
         eff_cols = grid_cols_ff;
      end
   end

   assign prod     = PROD_W'(eff_rows) * PROD_W'(eff_cols);
   assign total    = CNT_W'(prod);
   assign cols_idx = IDX_W'(eff_cols);

   always_comb begin
      nb_valid = 1'b0;
      nb_lin   = cur_lin_ff;
      nb_row   = cur_row_ff;
      nb_col   = cur_col_ff;
      case (nb_sel_ff)
         lslr_pkg::NB_UP: begin
            nb_valid = (cur_row_ff != '0);
            nb_lin   = cur_lin_ff - cols_idx;
            nb_row   = cur_row_ff - RW'(1);
         end
         lslr_pkg::NB_DOWN: begin
            nb_valid = (CMP_W'(cur_row_ff) + CMP_W'(1)) < CMP_W'(eff_rows);
            nb_lin   = cur_lin_ff + cols_idx;
            nb_row   = cur_row_ff + RW'(1);
         end
         lslr_pkg::NB_LEFT: begin
            nb_valid = (cur_col_ff != '0);
            nb_lin   = cur_lin_ff - IDX_W'(1);
            nb_col   = cur_col_ff - CLW'(1);
         end
         lslr_pkg::NB_RIGHT: begin
            nb_valid = (CMP_W'(cur_col_ff) + CMP_W'(1)) < CMP_W'(eff_cols);
            nb_lin   = cur_lin_ff + IDX_W'(1);
            nb_col   = cur_col_ff + CLW'(1);
         end
         default: begin
            nb_valid = 1'b0;
         end
      endcase
   end

   assign nb_take = cmd.nb_check && !vis_rd_ff && (cell_rd_ff == cur_letter_ff)
                    && (tail_ff < total);

   // memory port steering
   always_comb begin
      cell_we    = cmd.load && (load_idx_ff < total);
      cell_waddr = load_idx_ff[IDX_W-1:0];
      cell_raddr = cmd.nb_read ? nb_lin : q_lin;

      vis_raddr  = cmd.seed_read ? seed_ff[IDX_W-1:0] : nb_lin;
      vis_we     = cmd.clear || cmd.seed_take || nb_take;
      vis_wdata  = !cmd.clear;
      if (cmd.clear) begin
         vis_waddr = clr_ptr_ff;
      end else if (cmd.seed_take) begin
         vis_waddr = seed_ff[IDX_W-1:0];
      end else begin
         vis_waddr = nb_lin;
      end

      queue_we = cmd.seed_take || nb_take;
      if (cmd.seed_take) begin
         queue_waddr = '0;
         queue_wdata = {seed_ff[IDX_W-1:0], seed_row_ff, seed_col_ff};
      end else begin
         queue_waddr = tail_ff[IDX_W-1:0];
         queue_wdata = {nb_lin, nb_row, nb_col};
      end
   end

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem_ff[cell_waddr] <= req_letter;
      end
      cell_rd_ff <= cell_mem_ff[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem_ff[vis_waddr] <= vis_wdata;
      end
      vis_rd_ff <= vis_mem_ff[vis_raddr];
   end

   always_ff @(posedge clock) begin
      if (queue_we) begin
         queue_mem_ff[queue_waddr] <= queue_wdata;
      end
      queue_rd_ff <= queue_mem_ff[head_ff[IDX_W-1:0]];
   end

   assign col_wrap = (CMP_W'(seed_col_ff) + CMP_W'(1)) == CMP_W'(eff_cols);

   always_comb begin
      grid_rows_in  = grid_rows_ff;
      grid_cols_in  = grid_cols_ff;
      load_idx_in   = load_idx_ff;
      clr_ptr_in    = clr_ptr_ff;
      seed_in       = seed_ff;
      seed_row_in   = seed_row_ff;
      seed_col_in   = seed_col_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      region_in     = region_ff;
      best_in       = best_ff;
      nb_sel_in     = nb_sel_ff;
      rsp_valid_in  = rsp_valid_ff;
      cur_lin_in    = cur_lin_ff;
      cur_row_in    = cur_row_ff;
      cur_col_in    = cur_col_ff;
      cur_letter_in = cur_letter_ff;
      rsp_size_in   = rsp_size_ff;

      if (csr_we) begin
         case (csr_index)
            lslr_pkg::CSR_GRID_ROWS: grid_rows_in = csr_wdata;
            lslr_pkg::CSR_GRID_COLS: grid_cols_in = csr_wdata;
            default: ;
         endcase
      end

      // saturate at the grid size
      if (cmd.load) begin
         load_idx_in = (load_idx_ff < total) ? load_idx_ff + CNT_W'(1) : total;
      end
      if (cmd.clear_init) begin
         load_idx_in = '0;
         clr_ptr_in  = '0;
      end
      if (cmd.clear) begin
         clr_ptr_in = clr_ptr_ff + IDX_W'(1);
      end
      if (cmd.seed_init) begin
         seed_in     = '0;
         seed_row_in = '0;
         seed_col_in = '0;
         best_in     = '0;
      end
      if (cmd.region_end && (region_ff > best_ff)) begin
         best_in = region_ff;
      end
      if (cmd.seed_next) begin
         seed_in = seed_ff + CNT_W'(1);
         if (col_wrap) begin
            seed_col_in = '0;
            seed_row_in = seed_row_ff + RW'(1);
         end else begin
            seed_col_in = seed_col_ff + CLW'(1);
         end
      end
      if (cmd.seed_take) begin
         head_in   = '0;
         tail_in   = CNT_W'(1);
         region_in = '0;
      end
      if (cmd.pop) begin
         head_in = head_ff + CNT_W'(1);
      end
      if (cmd.cur) begin
         cur_lin_in = q_lin;
         cur_row_in = q_row;
         cur_col_in = q_col;
         region_in  = region_ff + CNT_W'(1);
         nb_sel_in  = lslr_pkg::NB_UP;
      end
      if (cmd.letter_latch) begin
         cur_letter_in = cell_rd_ff;
      end
      if (cmd.nb_next) begin
         nb_sel_in = nb_sel_ff + 2'd1;
      end
      if (nb_take) begin
         tail_in = tail_ff + CNT_W'(1);
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_size_in  = lslr_pkg::SIZE_W'(best_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff <= lslr_pkg::CFG_W'(64);
         grid_cols_ff <= lslr_pkg::CFG_W'(64);
         load_idx_ff  <= '0;
         clr_ptr_ff   <= '0;
         seed_ff      <= '0;
         seed_row_ff  <= '0;
         seed_col_ff  <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         region_ff    <= '0;
         best_ff      <= '0;
         nb_sel_ff    <= lslr_pkg::NB_UP;
         rsp_valid_ff <= 1'b0;
      end else begin
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         load_idx_ff  <= load_idx_in;
         clr_ptr_ff   <= clr_ptr_in;
         seed_ff      <= seed_in;
         seed_row_ff  <= seed_row_in;
         seed_col_ff  <= seed_col_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         region_ff    <= region_in;
         best_ff      <= best_in;
         nb_sel_ff    <= nb_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_lin_ff    <= cur_lin_in;
      cur_row_ff    <= cur_row_in;
      cur_col_ff    <= cur_col_in;
      cur_letter_ff <= cur_letter_in;
      rsp_size_ff   <= rsp_size_in;
   end

   always_comb begin
      status.last_clear  = (CNT_W'(clr_ptr_ff) + CNT_W'(1)) == total;
      status.seed_end    = (seed_ff == total);
      status.vis_hit     = vis_rd_ff;
      status.queue_empty = (head_ff == tail_ff);
      status.nb_valid    = nb_valid;
      status.nb_last     = (nb_sel_ff == lslr_pkg::NB_RIGHT);
      status.rsp_busy    = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_largest_size = rsp_size_ff;

endmodule

@@ src/largest_same_letter_region.sv @@
// Largest same-letter region. Cells load one per cycle while the block is ready; after the
// last cell the block clears the visited map for all N = rows*cols cells, then walks: it
// scans the seeds, closes a region when its queue empties, dequeues each cell, skips each
// off-grid neighbor and checks each in-grid one; the result follows once every seed is scanned.
// Input is held off during the walk. Synchronous active-high reset returns to loading,
// grid_rows = grid_cols = 64, no result pending; grid and queue memories are not cleared.
module largest_same_letter_region #(
   parameter int MAX_ROWS = lslr_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = lslr_pkg::DEF_MAX_COLS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [lslr_pkg::LETTER_W-1:0]  req_letter,
   input  logic                           req_last_cell,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [lslr_pkg::SIZE_W-1:0]    rsp_largest_size,
   input  logic                           csr_we,
   input  logic [lslr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lslr_pkg::CFG_W-1:0]     csr_wdata
);

   lslr_pkg::cmd_type    cmd;
   lslr_pkg::status_type status;

   lslr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_last_cell (req_last_cell),
      .status        (status),
      .cmd           (cmd)
   );

   lslr_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_letter       (req_letter),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_largest_size (rsp_largest_size)
   );

endmodule

@@ src/lslr_chk.sv @@
// Port-level checker for largest_same_letter_region, bound to the top level.
// Depends on lslr_pkg for field widths.
module lslr_chk #(
   parameter int MAX_ROWS = lslr_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = lslr_pkg::DEF_MAX_COLS
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_last_cell,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lslr_pkg::SIZE_W-1:0]   rsp_largest_size
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;

   // no result pending right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_largest_size))
      else $error("result dropped or changed while stalled");

   // the walk holds off the next grid
   a_walk_holds_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_cell |=> !req_ready && !$rose(rsp_valid))
      else $error("input taken or result shown right after last cell");

   // a region holds at least one cell and at most the whole grid (checked only below 8192 cells)
   a_size_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CELLS >= 8192) ||
                    ((rsp_largest_size != '0) &&
                     (32'(rsp_largest_size) <= 32'(CELLS))))
      else $error("region size out of range");

endmodule

bind largest_same_letter_region lslr_chk #(
   .MAX_ROWS (MAX_ROWS),
   .MAX_COLS (MAX_COLS)
) u_lslr_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_last_cell    (req_last_cell),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_largest_size (rsp_largest_size)
);

@@ test/tb_largest_same_letter_region.sv @@
// Testbench for largest_same_letter_region: streams grids of letters over the request
// channel and checks each largest-region size against a flood-fill predictor.
// Depends on lslr_pkg (widths, register indexes) and the largest_same_letter_region top.
module tb_largest_same_letter_region;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELLS        = lslr_pkg::DEF_MAX_ROWS * lslr_pkg::DEF_MAX_COLS;
   // largest grid (by cell count) the random phases build is 12 x 12
   localparam int PREFILL_DIM  = 12;
   localparam int RANDOM_ITEMS = 900;
   localparam int DRAIN_CYCLES = 32;
   localparam int LIMIT_CYCLES = 4_000_000;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [lslr_pkg::LETTER_W-1:0]  req_letter = '0;
   logic                           req_last_cell = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [lslr_pkg::SIZE_W-1:0]    rsp_largest_size;
   logic                           csr_we = 1'b0;
   logic [lslr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [lslr_pkg::CFG_W-1:0]     csr_wdata = '0;

   bit          calm = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned random_items = 0;

   class region_tracker;
      logic [lslr_pkg::CFG_W-1:0]    rows_reg;
      logic [lslr_pkg::CFG_W-1:0]    cols_reg;
      logic [lslr_pkg::LETTER_W-1:0] cells [CELLS];
      bit                            seen [CELLS];
      int unsigned                   walk [CELLS];
      int unsigned                   load_count;
      logic [lslr_pkg::SIZE_W-1:0]   pending_sizes [$];
      int unsigned                   mismatches;

      function new();
         rows_reg = lslr_pkg::CFG_W'(lslr_pkg::DEF_MAX_ROWS);
         cols_reg = lslr_pkg::CFG_W'(lslr_pkg::DEF_MAX_COLS);
         load_count = 0;
         mismatches = 0;
      endfunction

      function void write_reg(logic [lslr_pkg::CSR_IDX_W-1:0] idx,
                              logic [lslr_pkg::CFG_W-1:0] value);
         if (idx == lslr_pkg::CSR_GRID_ROWS) rows_reg = value;
         else if (idx == lslr_pkg::CSR_GRID_COLS) cols_reg = value;
      endfunction

      // zero reads as one, anything past the maximum reads as the maximum
      function int unsigned clamp_dim(logic [lslr_pkg::CFG_W-1:0] value, int unsigned limit);
         if (value == 0) return 1;
         if (value > limit) return limit;
         return value;
      endfunction

      function int unsigned eff_rows();
         return clamp_dim(rows_reg, lslr_pkg::DEF_MAX_ROWS);
      endfunction

      function int unsigned eff_cols();
         return clamp_dim(cols_reg, lslr_pkg::DEF_MAX_COLS);
      endfunction

      function int unsigned grid_cells();
         return eff_rows() * eff_cols();
      endfunction

      function logic [lslr_pkg::SIZE_W-1:0] flood_largest(int unsigned rows,
                                                          int unsigned cols);
         int unsigned total, head, tail, here, r, c, best, size, n;
         int unsigned nb [4];
         logic [lslr_pkg::LETTER_W-1:0] mark;
         total = rows * cols;
         best = 0;
         for (int i = 0; i < total; i++) seen[i] = 1'b0;
         for (int seed = 0; seed < total; seed++) begin
            if (seen[seed]) continue;
            seen[seed] = 1'b1;
            walk[0] = seed;
            head = 0;
            tail = 1;
            size = 0;
            while (head < tail) begin
               here = walk[head];
               head++;
               r = here / cols;
               c = here % cols;
               mark = cells[here];
               size++;
               n = 0;
               if (r > 0) begin nb[n] = here - cols; n++; end
               if (r + 1 < rows) begin nb[n] = here + cols; n++; end
               if (c > 0) begin nb[n] = here - 1; n++; end
               if (c + 1 < cols) begin nb[n] = here + 1; n++; end
               for (int k = 0; k < n; k++) begin
                  if (!seen[nb[k]] && cells[nb[k]] == mark) begin
                     seen[nb[k]] = 1'b1;
                     walk[tail] = nb[k];
                     tail++;
                  end
               end
            end
            if (size > best) best = size;
         end
         return best[lslr_pkg::SIZE_W-1:0];
      endfunction

      function void take_cell(logic [lslr_pkg::LETTER_W-1:0] letter, logic last);
         int unsigned total;
         total = grid_cells();
         if (load_count < total) begin
            cells[load_count] = letter;
            load_count++;
         end else begin
            load_count = total;
         end
         if (last) begin
            pending_sizes.push_back(flood_largest(eff_rows(), eff_cols()));
            load_count = 0;
         end
      endfunction

      function void match_size(logic [lslr_pkg::SIZE_W-1:0] got);
         logic [lslr_pkg::SIZE_W-1:0] want;
         if (pending_sizes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("largest_size %0d arrived with no grid pending", got);
            return;
         end
         want = pending_sizes.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("largest_size mismatch: expected %0d, got %0d", want, got);
         end
      endfunction
   endclass

   region_tracker board = new();

   largest_same_letter_region dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_letter       (req_letter),
      .req_last_cell    (req_last_cell),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_largest_size (rsp_largest_size),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic bit take_break();
      return !calm && ($urandom_range(99) < 14);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("tb_largest_same_letter_region: FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.match_size(rsp_largest_size);
      rsp_ready <= !take_break();
   end

   // Leaves valid high on return so the next cell can follow without a gap.
   task automatic send_cell(input logic [lslr_pkg::LETTER_W-1:0] letter, input logic last);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_letter    <= letter;
      req_last_cell <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.take_cell(letter, last);
   endtask

   // Drop valid, wait for every pending size, then let the block go idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_sizes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_dims(input logic [lslr_pkg::CFG_W-1:0] rows_v,
                             input logic [lslr_pkg::CFG_W-1:0] cols_v);
      csr_we    <= 1'b1;
      csr_index <= lslr_pkg::CSR_GRID_ROWS;
      csr_wdata <= rows_v;
      @(posedge clock);
      board.write_reg(lslr_pkg::CSR_GRID_ROWS, rows_v);
      csr_index <= lslr_pkg::CSR_GRID_COLS;
      csr_wdata <= cols_v;
      @(posedge clock);
      board.write_reg(lslr_pkg::CSR_GRID_COLS, cols_v);
      csr_we <= 1'b0;
   endtask

   task automatic random_phase();
      logic [lslr_pkg::CFG_W-1:0]    rows_v, cols_v;
      logic [lslr_pkg::LETTER_W-1:0] pool [3];
      int unsigned                   pick, total, count, grids, style;
      pick = $urandom_range(99);
      if (pick < 65) begin
         rows_v = lslr_pkg::CFG_W'($urandom_range(1, 6));
         cols_v = lslr_pkg::CFG_W'($urandom_range(1, 6));
      end else if (pick < 75) begin
         rows_v = lslr_pkg::CFG_W'($urandom_range(6, 12));
         cols_v = lslr_pkg::CFG_W'($urandom_range(6, 12));
      end else if (pick < 85) begin
         rows_v = lslr_pkg::CFG_W'($urandom_range(0, 8));
         cols_v = '0;
      end else begin
         // one full edge; values past the maximum clamp to it
         rows_v = lslr_pkg::CFG_W'($urandom_range(64, 127));
         cols_v = lslr_pkg::CFG_W'($urandom_range(0, 2));
      end
      if ($urandom_range(1)) {rows_v, cols_v} = {cols_v, rows_v};

      settle();
      write_dims(rows_v, cols_v);
      calm = ($urandom_range(7) == 0);
      total = board.grid_cells();
      grids = $urandom_range(1, 5);
      for (int g = 0; g < grids; g++) begin
         pick = $urandom_range(99);
         if (pick < 75) count = total;
         else if (pick < 87) count = total + $urandom_range(1, 3);
         else count = $urandom_range(1, total);
         style = $urandom_range(3);
         for (int p = 0; p < 3; p++) pool[p] = lslr_pkg::LETTER_W'($urandom_range(255));
         for (int i = 0; i < count; i++) begin
            if (style == 0) begin
               send_cell(lslr_pkg::LETTER_W'($urandom_range(255)), i == count - 1);
            end else begin
               send_cell(pool[$urandom_range(style - 1)], i == count - 1);
            end
            random_items++;
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Full 12 x 12 grid of one letter; also writes every cell that later
      // short grids can reach, so none of them reads an unwritten cell.
      calm = 1'b1;
      write_dims(lslr_pkg::CFG_W'(PREFILL_DIM), lslr_pkg::CFG_W'(PREFILL_DIM));
      for (int i = 0; i < PREFILL_DIM * PREFILL_DIM; i++)
         send_cell(8'hC3, i == PREFILL_DIM * PREFILL_DIM - 1);
      calm = 1'b0;

      // Zero dimensions read as a single cell; extra cells are dropped.
      settle();
      write_dims('0, '0);
      send_cell(8'h00, 1'b1);
      send_cell(8'hFF, 1'b1);
      send_cell(8'h5A, 1'b0);
      send_cell(8'h5A, 1'b0);
      send_cell(8'hA5, 1'b1);

      // Plus shape with isolated corners, then a short grid that keeps the tail.
      settle();
      write_dims(lslr_pkg::CFG_W'(3), lslr_pkg::CFG_W'(3));
      for (int i = 0; i < 9; i++) send_cell((i % 2 == 0 && i != 4) ? 8'h41 : 8'h42, i == 8);
      send_cell(8'h42, 1'b0);
      send_cell(8'h42, 1'b1);

      // Tall grid with clamped rows and a two-letter mix.
      settle();
      write_dims(lslr_pkg::CFG_W'(127), lslr_pkg::CFG_W'(2));
      for (int i = 0; i < lslr_pkg::DEF_MAX_ROWS * 2; i++)
         send_cell($urandom_range(1) ? 8'h61 : 8'h62, i == lslr_pkg::DEF_MAX_ROWS * 2 - 1);

      while (random_items < RANDOM_ITEMS) random_phase();

      settle();
      if (board.mismatches == 0 && board.pending_sizes.size() == 0) begin
         $display("tb_largest_same_letter_region: PASS");
      end else begin
         $display("tb_largest_same_letter_region: FAIL");
      end
      $finish;
   end

endmodule
